@@ hw/rtl/bbrp_pkg.sv @@
package bbrp_pkg;

   localparam int MaxBoxes    = 1024;
   localparam int RecordBytes = 24;
   localparam int RecWords    = RecordBytes / 4;
   localparam int HdrBytes    = 4;

   localparam int LenW   = 20;
   localparam int SizeW  = 16;
   localparam int IdxW   = 16;
   localparam int WordW  = 32;
   localparam int CntW   = 32;
   localparam int OffW   = $clog2(RecordBytes);
   localparam int WselW  = $clog2(RecWords);
   localparam int CsrIdW = 3;

   // ceil(2^17 / 3), exact for quotients of values below 2^17
   localparam int unsigned Recip3 = 43691;

   typedef enum logic [2:0] {
      ST_BOX       = 3'd0,
      ST_TOO_SMALL = 3'd1,
      ST_SIZE_MISM = 3'd2,
      ST_CNT_OVER  = 3'd3,
      ST_EXP_OVER  = 3'd4
   } status_type;

   localparam logic [CsrIdW-1:0] CSR_BUF_LEN  = 3'd0;
   localparam logic [CsrIdW-1:0] CSR_IMG_W    = 3'd1;
   localparam logic [CsrIdW-1:0] CSR_IMG_H    = 3'd2;
   localparam logic [CsrIdW-1:0] CSR_EXP_BOX  = 3'd3;
   localparam logic [CsrIdW-1:0] CSR_STRICT   = 3'd4;

   typedef struct packed {
      status_type                     status;
      logic [IdxW-1:0]                index;
      logic [RecWords-1:0][WordW-1:0] words;
   } pend_type;

   function automatic logic signed [WordW-1:0] sat_add(input logic signed [WordW-1:0] a,
                                                      input logic signed [WordW-1:0] b);
      logic signed [WordW:0] s;
      begin
         s = {a[WordW-1], a} + {b[WordW-1], b};
         if (s[WordW] != s[WordW-1]) begin
            sat_add = s[WordW] ? {1'b1, {(WordW-1){1'b0}}} : {1'b0, {(WordW-1){1'b1}}};
         end else begin
            sat_add = s[WordW-1:0];
         end
      end
   endfunction

   function automatic logic signed [WordW-1:0] clamp_lim(input logic signed [WordW-1:0] v,
                                                        input logic [SizeW-1:0] lim);
      logic signed [WordW-1:0] l;
      begin
         l = $signed({{(WordW-SizeW){1'b0}}, lim});
         if (v > l) begin
            clamp_lim = l;
         end else if (v < 0) begin
            clamp_lim = '0;
         end else begin
            clamp_lim = v;
         end
      end
   endfunction

endpackage

@@ hw/rtl/bbox_record_parser.sv @@
// channel   ports                  moves
// -------   --------------------   ---------------------------------------
// request   req_valid/req_stall    one buffer byte (req_data_byte)
// response  rsp_valid/rsp_stall    one box or one status code
// config    csr_write_en           csr_index selects, csr_data carries value
//
// one request byte is taken every cycle while req_stall is low; a box leaves
// after its last byte, through a pending stage and then the output register.
// req_stall rises only while the pending stage is full and the output is held.
// sizes derived from buffer_length settle through the payload, box limit and size check registers after a write to it.
// reset is synchronous; any valid csr write restarts the buffer.
module bbox_record_parser import bbrp_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [7:0]               req_data_byte,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [2:0]               rsp_status,
   output logic [IdxW-1:0]          rsp_box_index,
   output logic signed [WordW-1:0]  rsp_left,
   output logic signed [WordW-1:0]  rsp_top,
   output logic signed [WordW-1:0]  rsp_right,
   output logic signed [WordW-1:0]  rsp_bottom,
   output logic [WordW-1:0]         rsp_score_bits,
   output logic signed [WordW-1:0]  rsp_class_id,
   input  logic                     csr_write_en,
   input  logic [CsrIdW-1:0]        csr_index,
   input  logic [LenW-1:0]          csr_data
);

   // configuration
   logic [LenW-1:0]  buf_len_ff;
   logic [SizeW-1:0] img_w_ff, img_h_ff, exp_box_ff;
   logic             strict_ff;
   logic             csr_hit;

   // derived sizes
   logic [LenW-1:0]    payload_ff;
   logic [SizeW-1:0]   maxb_ff;
   logic               size_ok_ff;
   logic [LenW:0]      esize_ff;
   logic [2*LenW-6:0]  maxb_prod;
   logic [LenW:0]      maxb_bytes;

   // parse state
   logic [LenW-1:0]  byte_pos_ff, byte_pos_in;
   logic [CntW-1:0]  box_count_ff, box_count_in;
   logic             stopped_ff, stopped_in;
   logic [OffW-1:0]  off_ff, off_in;
   logic [IdxW-1:0]  rec_ff, rec_in;
   logic [WordW-1:0] rec_words_ff [RecWords];

   // pending stage and output register
   pend_type pend_ff, pend_in;
   logic     pend_valid_ff, pend_valid_in;
   logic     produce;
   logic     out_free, req_take, active;

   logic                    rsp_valid_ff;
   status_type              rsp_status_ff;
   logic [IdxW-1:0]         rsp_index_ff;
   logic signed [WordW-1:0] rsp_left_ff, rsp_top_ff, rsp_right_ff, rsp_bottom_ff;
   logic [WordW-1:0]        rsp_score_ff, rsp_class_ff;

   // header evaluation
   logic [CntW-1:0]  full_cnt, cnt_sel;
   logic             in_rec;
   logic [WselW-1:0] wsel;

   // box evaluation
   logic signed [WordW-1:0] x1, y1, x2, y2, cx1, cy1, cx2, cy2;
   logic                    clamp_en, keep;

   assign out_free  = ~rsp_valid_ff | ~rsp_stall;
   assign req_stall = pend_valid_ff & ~out_free;
   assign req_take  = req_valid & ~req_stall;
   assign active    = req_take & ~stopped_ff & (byte_pos_ff < buf_len_ff);
   assign csr_hit   = csr_write_en & (csr_index <= CSR_STRICT);

   always_ff @(posedge clock) begin
      if (reset) begin
         buf_len_ff <= '0;
         img_w_ff   <= '0;
         img_h_ff   <= '0;
         exp_box_ff <= '0;
         strict_ff  <= 1'b0;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_BUF_LEN: buf_len_ff <= csr_data;
            CSR_IMG_W:   img_w_ff   <= csr_data[SizeW-1:0];
            CSR_IMG_H:   img_h_ff   <= csr_data[SizeW-1:0];
            CSR_EXP_BOX: exp_box_ff <= csr_data[SizeW-1:0];
            CSR_STRICT:  strict_ff  <= csr_data[0];
            default: begin
            end
         endcase
      end
   end

   // payload / 24 as (payload / 8) * ceil(2^17 / 3) >> 17
   assign maxb_prod  = payload_ff[LenW-1:3] * Recip3[LenW-3:0];
   assign maxb_bytes = {1'b0, maxb_ff, 4'b0} + {2'b0, maxb_ff, 3'b0};

   always_ff @(posedge clock) begin
      payload_ff <= buf_len_ff - LenW'(HdrBytes);
      maxb_ff    <= maxb_prod[LenW-3+SizeW-1:LenW-3];
      size_ok_ff <= (maxb_bytes == {1'b0, payload_ff});
      esize_ff   <= {1'b0, exp_box_ff, 4'b0} + {2'b0, exp_box_ff, 3'b0}
                    + (LenW+1)'(HdrBytes);
   end

   assign full_cnt = {req_data_byte, box_count_ff[23:0]};
   assign in_rec   = {{(CntW-IdxW){1'b0}}, rec_ff} < box_count_ff;
   assign wsel     = off_ff[OffW-1:2];

   always_comb begin
      byte_pos_in  = byte_pos_ff;
      box_count_in = box_count_ff;
      stopped_in   = stopped_ff;
      off_in       = off_ff;
      rec_in       = rec_ff;
      produce      = 1'b0;
      pend_in      = pend_ff;
      cnt_sel      = full_cnt;
      if (csr_hit) begin
         byte_pos_in  = '0;
         box_count_in = '0;
         stopped_in   = 1'b0;
         off_in       = '0;
         rec_in       = '0;
      end else if (active) begin
         byte_pos_in = byte_pos_ff + 1'b1;
         if (byte_pos_ff < LenW'(HdrBytes)) begin
            case (byte_pos_ff[1:0])
               2'd0: box_count_in[7:0]   = req_data_byte;
               2'd1: box_count_in[15:8]  = req_data_byte;
               2'd2: box_count_in[23:16] = req_data_byte;
               default: box_count_in[31:24] = req_data_byte;
            endcase
            pend_in.index = '0;
            pend_in.words = '0;
            if (buf_len_ff < LenW'(HdrBytes)) begin
               // short buffer, judged at its last byte
               if (byte_pos_ff == buf_len_ff - 1'b1) begin
                  stopped_in     = 1'b1;
                  produce        = strict_ff;
                  pend_in.status = ST_TOO_SMALL;
               end
            end else if (byte_pos_ff == LenW'(HdrBytes - 1)) begin
               if (!size_ok_ff) begin
                  stopped_in     = 1'b1;
                  produce        = strict_ff;
                  pend_in.status = ST_SIZE_MISM;
               end else if (strict_ff && full_cnt > {{(CntW-SizeW){1'b0}}, maxb_ff}) begin
                  stopped_in     = 1'b1;
                  produce        = 1'b1;
                  pend_in.status = ST_CNT_OVER;
               end else begin
                  if (full_cnt > {{(CntW-SizeW){1'b0}}, maxb_ff}) begin
                     cnt_sel = {{(CntW-SizeW){1'b0}}, maxb_ff};
                  end
                  if (exp_box_ff != '0 && strict_ff &&
                      {1'b0, buf_len_ff} > esize_ff) begin
                     stopped_in     = 1'b1;
                     produce        = 1'b1;
                     pend_in.status = ST_EXP_OVER;
                  end else if (exp_box_ff != '0 && !strict_ff &&
                               {1'b0, buf_len_ff} < esize_ff) begin
                     stopped_in = 1'b1;
                  end
                  if (cnt_sel > CntW'(MaxBoxes)) begin
                     box_count_in = CntW'(MaxBoxes);
                  end else begin
                     box_count_in = cnt_sel;
                  end
               end
            end
         end else begin
            if (off_ff == OffW'(RecordBytes - 1)) begin
               off_in = '0;
               rec_in = rec_ff + 1'b1;
               if (in_rec) begin
                  produce        = 1'b1;
                  pend_in.status = ST_BOX;
                  pend_in.index  = rec_ff;
                  for (int i = 0; i < RecWords - 1; i++) begin
                     pend_in.words[i] = rec_words_ff[i];
                  end
                  pend_in.words[RecWords-1] = {req_data_byte,
                                              rec_words_ff[RecWords-1][23:0]};
               end
            end else begin
               off_in = off_ff + 1'b1;
            end
         end
      end
      pend_valid_in = produce | (pend_valid_ff & ~out_free);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_pos_ff   <= '0;
         box_count_ff  <= '0;
         stopped_ff    <= 1'b0;
         off_ff        <= '0;
         rec_ff        <= '0;
         pend_valid_ff <= 1'b0;
      end else begin
         byte_pos_ff   <= byte_pos_in;
         box_count_ff  <= box_count_in;
         stopped_ff    <= stopped_in;
         off_ff        <= off_in;
         rec_ff        <= rec_in;
         pend_valid_ff <= pend_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (produce) begin
         pend_ff <= pend_in;
      end
      if (active && !csr_hit && byte_pos_ff >= LenW'(HdrBytes) && in_rec) begin
         rec_words_ff[wsel][8*off_ff[1:0] +: 8] <= req_data_byte;
      end
   end

   // corner arithmetic on the pending record
   assign clamp_en = (img_w_ff != '0) && (img_h_ff != '0);
   assign x1 = $signed(pend_ff.words[0]);
   assign y1 = $signed(pend_ff.words[1]);
   assign x2 = sat_add(x1, $signed(pend_ff.words[2]));
   assign y2 = sat_add(y1, $signed(pend_ff.words[3]));
   assign cx1 = clamp_en ? clamp_lim(x1, img_w_ff) : x1;
   assign cy1 = clamp_en ? clamp_lim(y1, img_h_ff) : y1;
   assign cx2 = clamp_en ? clamp_lim(x2, img_w_ff) : x2;
   assign cy2 = clamp_en ? clamp_lim(y2, img_h_ff) : y2;
   assign keep = (pend_ff.status != ST_BOX) || strict_ff || ((cx2 > cx1) && (cy2 > cy1));

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= pend_valid_ff & keep;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free && pend_valid_ff) begin
         rsp_status_ff <= pend_ff.status;
         rsp_index_ff  <= pend_ff.index;
         if (pend_ff.status == ST_BOX) begin
            rsp_left_ff   <= cx1;
            rsp_top_ff    <= cy1;
            rsp_right_ff  <= cx2;
            rsp_bottom_ff <= cy2;
            rsp_score_ff  <= pend_ff.words[4];
            rsp_class_ff  <= pend_ff.words[5];
         end else begin
            rsp_left_ff   <= '0;
            rsp_top_ff    <= '0;
            rsp_right_ff  <= '0;
            rsp_bottom_ff <= '0;
            rsp_score_ff  <= '0;
            rsp_class_ff  <= '0;
         end
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_box_index  = rsp_index_ff;
   assign rsp_left       = rsp_left_ff;
   assign rsp_top        = rsp_top_ff;
   assign rsp_right      = rsp_right_ff;
   assign rsp_bottom     = rsp_bottom_ff;
   assign rsp_score_bits = rsp_score_ff;
   assign rsp_class_id   = $signed(rsp_class_ff);

`ifndef SYNTH
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff != ST_BOX) |->
         (rsp_left_ff == '0 && rsp_right_ff == '0 && rsp_score_ff == '0 &&
          rsp_index_ff == '0))
      else $error("status response carries box fields");

   a_stop_hold: assert property (@(posedge clock) disable iff (reset)
      (stopped_ff && !csr_write_en) |=> $stable(byte_pos_ff))
      else $error("byte position moved while stopped");

   a_cnt_cap: assert property (@(posedge clock) disable iff (reset)
      (byte_pos_ff >= LenW'(HdrBytes) && !stopped_ff) |-> (box_count_ff <= CntW'(MaxBoxes)))
      else $error("box count above limit after header");

   a_idx_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff == ST_BOX) |->
         ({{(CntW-IdxW){1'b0}}, rsp_index_ff} < box_count_ff))
      else $error("box index beyond count");
`endif

endmodule
